[rtl/tpr_pkg.sv]
// Package for the tachometer period-to-rpm unit.
// Holds the shared types, codes, register defaults and arithmetic widths.
// No dependencies.
package tpr_pkg;

    // Widths fixed by the interface.
    localparam int CLOCK_HZ_W      = 28;
    localparam int PRESCALE_W      = 16;
    localparam int INPUT_CAPTURE_W = 16;
    localparam int SPEED_W         = 32;
    localparam int KIND_W          = 2;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    // 60 * clock needs 34 bits for a 28-bit clock register.
    localparam int SPEED_FACTOR = 60;
    localparam int NUM_W        = CLOCK_HZ_W + 6;

    // Prescaler plus one needs one bit more than the register.
    localparam int PRESCALE_P1_W = PRESCALE_W + 1;

    localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET = CLOCK_HZ_W'(170000000);
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = PRESCALE_W'(2593);

    localparam logic [SPEED_W-1:0] SPEED_ERROR = 32'hFFFF_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_MAX   = 32'hFFFF_FFFE;

    // Parameter defaults.
    localparam int CAPTURE_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH_DEFAULT  = 2;

    // Configuration register indexes, decoded from paddr[2].
    typedef enum logic {
        REG_CLOCK_HZ = 1'b0,
        REG_PRESCALE = 1'b1
    } t_reg_index;

    typedef enum logic [KIND_W-1:0] {
        KIND_CAPTURE = 2'd0,
        KIND_EXPIRY  = 2'd1,
        KIND_OVERRUN = 2'd2,
        KIND_UNUSED  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_SECOND = 2'd1,
        PH_EXPIRY = 2'd2
    } t_phase;

    // Command passed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_ZERO   = 2'd1,
        OP_ERROR  = 2'd2,
        OP_DIVIDE = 2'd3
    } t_cmd_op;

    localparam int OP_W = 2;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_PREP = 2'd1,
        BK_DIV  = 2'd2,
        BK_DONE = 2'd3
    } t_back_state;

endpackage

[rtl/tpr_front.sv]
// Front end of the tachometer unit: accepts events, runs the capture phase
// machine and turns each item into one command for the back end.
// Depends on tpr_pkg.
module tpr_front
    import tpr_pkg::*;
#(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic [INPUT_CAPTURE_W-1:0] i_capture_value,
    output t_cmd_op                    o_op,
    output logic [CAPTURE_BITS-1:0]    o_diff
);

    localparam int USE_W = (CAPTURE_BITS < INPUT_CAPTURE_W) ? CAPTURE_BITS : INPUT_CAPTURE_W;

    t_phase                  r_phase, n_phase;
    logic [CAPTURE_BITS-1:0] r_first, n_first;
    logic [CAPTURE_BITS-1:0] r_second, n_second;
    logic [CAPTURE_BITS-1:0] cap;

    assign cap = CAPTURE_BITS'(i_capture_value[USE_W-1:0]);

    always_comb begin
        n_phase  = r_phase;
        n_first  = r_first;
        n_second = r_second;
        o_op     = OP_HOLD;
        o_diff   = '0;
        unique case (t_kind'(i_kind))
            KIND_CAPTURE: begin
                // Captures after the second one in a window are ignored.
                unique case (r_phase)
                    PH_SECOND: begin
                        n_second = cap;
                        n_phase  = PH_EXPIRY;
                    end
                    PH_EXPIRY: begin
                    end
                    default: begin
                        n_first = cap;
                        n_phase = PH_SECOND;
                    end
                endcase
            end
            KIND_EXPIRY: begin
                n_phase = PH_FIRST;
                if (r_phase == PH_EXPIRY) begin
                    if (r_second > r_first) begin
                        o_op   = OP_DIVIDE;
                        o_diff = r_second - r_first;
                    end else begin
                        o_op = OP_ERROR;
                    end
                end else begin
                    o_op = OP_ZERO;
                end
            end
            KIND_OVERRUN: begin
                n_phase = PH_FIRST;
            end
            KIND_UNUSED: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_first  <= '0;
            r_second <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

endmodule

[rtl/tpr_queue.sv]
// Short command queue between the front end and the back end.
// Generic in width and depth; no package dependencies.
module tpr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/tpr_back.sv]
// Back end of the tachometer unit: executes commands, runs the restoring
// divider for the speed and holds the output register and the speed state.
// Depends on tpr_pkg.
module tpr_back
    import tpr_pkg::*;
#(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  t_cmd_op                  i_op,
    input  logic [CAPTURE_BITS-1:0]  i_diff,
    output logic                     o_pop,
    input  logic [CLOCK_HZ_W-1:0]    i_clock_hz,
    input  logic [PRESCALE_W-1:0]    i_prescale,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [SPEED_W-1:0]       o_speed_rpm,
    output logic                     o_speed_updated
);

    localparam int DEN_W = PRESCALE_P1_W + CAPTURE_BITS;
    localparam int CNT_W = $clog2(NUM_W);

    t_back_state             r_state, n_state;
    logic [CAPTURE_BITS-1:0] r_diff;
    logic [NUM_W-1:0]        r_num;
    logic [DEN_W-1:0]        r_den;
    logic [DEN_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_cnt;
    logic [SPEED_W-1:0]      r_speed;
    logic [SPEED_W-1:0]      r_out_speed;
    logic                    r_out_upd;
    logic                    r_out_valid;

    logic                    out_free;
    logic                    load;
    logic [SPEED_W-1:0]      load_speed;
    logic                    load_upd;
    logic                    take_div;
    logic [DEN_W:0]          trial;
    logic                    q_bit;
    logic [SPEED_W-1:0]      quotient_sat;
    logic [PRESCALE_P1_W-1:0] prescale_p1;

    assign out_free = !r_out_valid || i_ready;

    // One quotient bit per cycle; r_num ends up holding the quotient.
    assign trial        = {r_rem, r_num[NUM_W-1]};
    assign q_bit        = (trial >= {1'b0, r_den});
    assign quotient_sat = (r_num > NUM_W'(SPEED_MAX)) ? SPEED_MAX : r_num[SPEED_W-1:0];
    assign prescale_p1  = PRESCALE_P1_W'(i_prescale) + PRESCALE_P1_W'(1);

    always_comb begin
        n_state    = r_state;
        o_pop      = 1'b0;
        load       = 1'b0;
        load_speed = r_speed;
        load_upd   = 1'b0;
        take_div   = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_pop = 1'b1;
                    unique case (i_op)
                        OP_DIVIDE: begin
                            take_div = 1'b1;
                            n_state  = BK_PREP;
                        end
                        OP_ZERO: begin
                            load       = 1'b1;
                            load_speed = '0;
                            load_upd   = 1'b1;
                        end
                        OP_ERROR: begin
                            load       = 1'b1;
                            load_speed = SPEED_ERROR;
                            load_upd   = 1'b1;
                        end
                        OP_HOLD: begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            BK_PREP: begin
                n_state = BK_DIV;
            end
            BK_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    load       = 1'b1;
                    load_speed = quotient_sat;
                    load_upd   = 1'b1;
                    n_state    = BK_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider datapath.
    always_ff @(posedge i_clk) begin
        if (take_div) begin
            r_diff <= i_diff;
        end
        if (r_state == BK_PREP) begin
            r_num <= NUM_W'(i_clock_hz) * NUM_W'(SPEED_FACTOR);
            r_den <= DEN_W'(prescale_p1) * DEN_W'(r_diff);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == BK_DIV) begin
            r_rem <= q_bit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], q_bit};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_speed     <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_speed     <= load_speed;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_speed <= load_speed;
            r_out_upd   <= load_upd;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_speed_rpm     = r_out_speed;
    assign o_speed_updated = r_out_upd;

endmodule

[rtl/tachometer_period_to_rpm_unit.sv]
// Tachometer period-to-rpm unit: front end, command queue, divider back end.
// A window expiry that computes a speed runs through the 34-step restoring
// divider in the back end, which takes one speed computation at a time; later
// items wait in the queue meanwhile. Other items go through at one a cycle when
// the result side is ready and no division is in progress.
// Reset (synchronous, active low) rearms the phase machine, clears the speed
// and the queue, and loads the default clock and prescaler registers.
module tachometer_period_to_rpm_unit
    import tpr_pkg::*;
#(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEFAULT,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    output logic [PDATA_W-1:0]         prdata,
    output logic                       pready,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic [INPUT_CAPTURE_W-1:0] i_capture_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [SPEED_W-1:0]         o_speed_rpm,
    output logic                       o_speed_updated
);

    localparam int CMD_W = OP_W + CAPTURE_BITS;

    logic [CLOCK_HZ_W-1:0]   r_clock_hz;
    logic [PRESCALE_W-1:0]   r_prescale;
    t_reg_index              reg_index;
    logic                    cfg_write;

    logic                    accept;
    t_cmd_op                 front_op;
    logic [CAPTURE_BITS-1:0] front_diff;
    logic [CMD_W-1:0]        q_out;
    logic                    q_empty;
    logic                    q_full;
    logic                    q_pop;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_index = t_reg_index'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_HZ_RESET;
            r_prescale <= PRESCALE_RESET;
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_CLOCK_HZ: r_clock_hz <= pwdata[CLOCK_HZ_W-1:0];
                REG_PRESCALE: r_prescale <= pwdata[PRESCALE_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_CLOCK_HZ: prdata = PDATA_W'(r_clock_hz);
            REG_PRESCALE: prdata = PDATA_W'(r_prescale);
        endcase
    end

    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    tpr_front #(
        .CAPTURE_BITS(CAPTURE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_kind         (i_kind),
        .i_capture_value(i_capture_value),
        .o_op           (front_op),
        .o_diff         (front_diff)
    );

    tpr_queue #(
        .WIDTH(CMD_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data ({front_op, front_diff}),
        .i_pop  (q_pop),
        .o_data (q_out),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    tpr_back #(
        .CAPTURE_BITS(CAPTURE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!q_empty),
        .i_op           (t_cmd_op'(q_out[CMD_W-1:CAPTURE_BITS])),
        .i_diff         (q_out[CAPTURE_BITS-1:0]),
        .o_pop          (q_pop),
        .i_clock_hz     (r_clock_hz),
        .i_prescale     (r_prescale),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_speed_rpm    (o_speed_rpm),
        .o_speed_updated(o_speed_updated)
    );

endmodule

[tb/tb.sv]
// Self-checking testbench for the tachometer period-to-rpm unit.
// Depends on tpr_pkg and tachometer_period_to_rpm_unit; the speed predictor is kept
// in a small scoreboard class that is fed from the handshake monitor.
module tb;
    import tpr_pkg::*;

    class speed_scoreboard;
        logic [CLOCK_HZ_W-1:0]      clock_hz;
        logic [PRESCALE_W-1:0]      prescale;
        t_phase                     phase;
        logic [INPUT_CAPTURE_W-1:0] first_cap;
        logic [INPUT_CAPTURE_W-1:0] second_cap;
        logic [SPEED_W-1:0]         speed;
        logic [SPEED_W-1:0]         pending_speed[$];
        logic                       pending_updated[$];
        int                         fail_count;

        function new();
            clock_hz   = CLOCK_HZ_RESET;
            prescale   = PRESCALE_RESET;
            phase      = PH_FIRST;
            first_cap  = '0;
            second_cap = '0;
            speed      = '0;
            fail_count = 0;
        endfunction

        function void set_reg(t_reg_index idx, logic [PDATA_W-1:0] value);
            if (idx == REG_CLOCK_HZ) begin
                clock_hz = value[CLOCK_HZ_W-1:0];
            end else begin
                prescale = value[PRESCALE_W-1:0];
            end
        endfunction

        // Exact integer form of 60 * clock / ((prescale + 1) * period).
        function logic [SPEED_W-1:0] window_speed();
            logic [63:0] num;
            logic [63:0] den;
            logic [63:0] quot;
            if (second_cap <= first_cap) begin
                return SPEED_ERROR;
            end
            num  = 64'(clock_hz) * 64'd60;
            den  = (64'(prescale) + 64'd1) * 64'(second_cap - first_cap);
            quot = num / den;
            if (quot > 64'(SPEED_MAX)) begin
                quot = 64'(SPEED_MAX);
            end
            return quot[SPEED_W-1:0];
        endfunction

        function void note_input(t_kind kind, logic [INPUT_CAPTURE_W-1:0] cap);
            logic updated;
            updated = 1'b0;
            case (kind)
                KIND_OVERRUN: begin
                    phase = PH_FIRST;
                end
                KIND_EXPIRY: begin
                    speed   = (phase == PH_EXPIRY) ? window_speed() : '0;
                    updated = 1'b1;
                    phase   = PH_FIRST;
                end
                KIND_CAPTURE: begin
                    if (phase == PH_SECOND) begin
                        second_cap = cap;
                        phase      = PH_EXPIRY;
                    end else if (phase != PH_EXPIRY) begin
                        first_cap = cap;
                        phase     = PH_SECOND;
                    end
                end
                default: begin
                end
            endcase
            pending_speed.push_back(speed);
            pending_updated.push_back(updated);
        endfunction

        task report(string msg);
            if (fail_count < 40) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
            fail_count++;
        endtask

        task check_result(logic [SPEED_W-1:0] got_speed, logic got_updated);
            logic [SPEED_W-1:0] want_speed;
            logic               want_updated;
            if (pending_speed.size() == 0) begin
                report("result item arrived with nothing pending");
            end else begin
                want_speed   = pending_speed.pop_front();
                want_updated = pending_updated.pop_front();
                if (got_speed !== want_speed) begin
                    report($sformatf("speed_rpm got %h want %h", got_speed, want_speed));
                end
                if (got_updated !== want_updated) begin
                    report($sformatf("speed_updated got %b want %b", got_updated,
                                     want_updated));
                end
            end
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;
    logic                       in_valid = 1'b0;
    logic                       o_in_ready;
    logic [KIND_W-1:0]          kind_r = '0;
    logic [INPUT_CAPTURE_W-1:0] cap_r = '0;
    logic                       o_out_valid;
    logic                       out_ready = 1'b0;
    logic [SPEED_W-1:0]         o_speed_rpm;
    logic                       o_speed_updated;

    speed_scoreboard sb = new();

    int burst_left = 0;
    int items_sent = 0;
    int gap_chance = 2;
    bit squeeze_req = 1'b0;
    bit squeeze_done = 1'b0;

    tachometer_period_to_rpm_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (kind_r),
        .i_capture_value (cap_r),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_speed_rpm     (o_speed_rpm),
        .o_speed_updated (o_speed_updated)
    );

    always #6 i_clk = ~i_clk;

    // Input items are noted before results are checked, so one edge is handled in order.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && o_in_ready) begin
                sb.note_input(t_kind'(kind_r), cap_r);
            end
            if (o_out_valid && out_ready) begin
                sb.check_result(o_speed_rpm, o_speed_updated);
            end
        end
    end

    // Result side: stall patterns that change at random, and one long
    // hold-off on request so that the queue fills and the input side stalls.
    initial begin
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (squeeze_req && !squeeze_done) begin
                out_ready = 1'b0;
                repeat (600) @(negedge i_clk);
                squeeze_done = 1'b1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(5, 80);
            end
            mode_left--;
            case (mode)
                0: out_ready = 1'b1;
                1: out_ready = 1'($urandom_range(0, 1));
                2: out_ready = ($urandom_range(0, 7) == 0);
                default: out_ready = ~out_ready;
            endcase
        end
    end

    initial begin
        #7200000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_item(t_kind kind, logic [INPUT_CAPTURE_W-1:0] cap);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) < gap_chance) ? $urandom_range(1, 10) : 0;
            if (gap > 0) begin
                @(negedge i_clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_valid = 1'b1;
        kind_r   = kind;
        cap_r    = cap;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Waits until every pending result has come, then a margin for the divider.
    task automatic drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (sb.pending_speed.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic reg_write(t_reg_index idx, logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] want;
        logic [PDATA_W-1:0] got;
        want = (idx == REG_CLOCK_HZ) ? PDATA_W'(value[CLOCK_HZ_W-1:0])
                                     : PDATA_W'(value[PRESCALE_W-1:0]);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        // Read the register back to confirm the write landed.
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== want) begin
            sb.report($sformatf("register %0d read %h want %h", idx, got, want));
        end
    endtask

    // A well-formed measurement window with random content, sometimes broken.
    task automatic send_window();
        logic [INPUT_CAPTURE_W-1:0] first;
        logic [INPUT_CAPTURE_W-1:0] delta;
        int extra;
        first = INPUT_CAPTURE_W'($urandom);
        case ($urandom_range(0, 7))
            0, 1, 2: delta = INPUT_CAPTURE_W'($urandom_range(1, 16));
            3, 4:    delta = INPUT_CAPTURE_W'($urandom_range(17, 2000));
            5:       delta = INPUT_CAPTURE_W'($urandom);
            6:       delta = 16'hFFFF - first;
            default: delta = '0;
        endcase
        send_item(KIND_CAPTURE, first);
        if ($urandom_range(0, 9) == 0) begin
            send_item(KIND_OVERRUN, INPUT_CAPTURE_W'($urandom));
        end
        send_item(KIND_CAPTURE, first + delta);
        extra = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (extra) send_item(KIND_CAPTURE, INPUT_CAPTURE_W'($urandom));
        send_item(KIND_EXPIRY, INPUT_CAPTURE_W'($urandom));
    endtask

    initial begin
        int phase_no;
        int target;
        logic [PDATA_W-1:0] clk_val;
        logic [PDATA_W-1:0] pre_val;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part with the reset configuration.
        send_item(KIND_EXPIRY, 16'h0000);
        send_item(KIND_CAPTURE, 16'h0000);
        send_item(KIND_CAPTURE, 16'hFFFF);
        send_item(KIND_CAPTURE, 16'h1234);
        send_item(KIND_EXPIRY, 16'hFFFF);
        send_item(KIND_CAPTURE, 16'hFFFF);
        send_item(KIND_CAPTURE, 16'h0000);
        send_item(KIND_EXPIRY, 16'h0000);
        send_item(KIND_CAPTURE, 16'd100);
        send_item(KIND_CAPTURE, 16'd100);
        send_item(KIND_EXPIRY, 16'h0000);
        send_item(KIND_CAPTURE, 16'd5);
        send_item(KIND_OVERRUN, 16'hAAAA);
        send_item(KIND_EXPIRY, 16'h5555);
        send_item(KIND_UNUSED, 16'hFFFF);
        send_item(KIND_CAPTURE, 16'd10);
        send_item(KIND_UNUSED, 16'h0000);
        send_item(KIND_CAPTURE, 16'd20);
        send_item(KIND_EXPIRY, 16'h0000);
        drain();

        // Largest clock with no prescaling and a one-tick period saturates.
        reg_write(REG_CLOCK_HZ, 32'h0FFF_FFFF);
        reg_write(REG_PRESCALE, 32'h0000_0000);
        send_item(KIND_CAPTURE, 16'd5);
        send_item(KIND_CAPTURE, 16'd6);
        send_item(KIND_EXPIRY, 16'h0000);
        drain();

        reg_write(REG_CLOCK_HZ, 32'h0000_0000);
        send_item(KIND_CAPTURE, 16'd1);
        send_item(KIND_CAPTURE, 16'd2);
        send_item(KIND_EXPIRY, 16'h0000);
        drain();

        // Random part in several configuration phases.
        squeeze_req = 1'b1;
        for (phase_no = 0; phase_no < 5; phase_no++) begin
            if (phase_no == 0) begin
                clk_val = 32'h0FFF_FFFF;
                pre_val = 32'h0000_FFFF;
            end else begin
                case ($urandom_range(0, 5))
                    0:       clk_val = 32'd1;
                    1:       clk_val = 32'd200000000;
                    2:       clk_val = 32'h0FFF_FFFF;
                    3:       clk_val = {4'h0, 28'($urandom)};
                    default: clk_val = $urandom_range(1, 200000000);
                endcase
                case ($urandom_range(0, 4))
                    0:       pre_val = 32'd0;
                    1:       pre_val = 32'h0000_FFFF;
                    2:       pre_val = $urandom_range(0, 15);
                    default: pre_val = $urandom_range(0, 65535);
                endcase
            end
            reg_write(REG_CLOCK_HZ, clk_val);
            reg_write(REG_PRESCALE, pre_val);
            gap_chance = (phase_no == 2) ? 0 : $urandom_range(1, 3);
            target = items_sent + 230;
            while (items_sent < target) begin
                if ($urandom_range(0, 3) != 0) begin
                    send_window();
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        send_item(t_kind'($urandom_range(0, 3)),
                                  INPUT_CAPTURE_W'($urandom));
                    end
                end
            end
            drain();
        end

        if (sb.fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
